@@ design/dsw_pkg.sv @@
// Shared types, constants and helper functions for the sweep tuning word generator.
package dsw_pkg;

    localparam int FREQ_W     = 24;
    localparam int CNT_W      = 16;
    localparam int TW_W       = 28;
    localparam int HALF_W     = 14;
    localparam int WORD_W     = 16;
    localparam int WAVE_W     = 2;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int MASTER_CLOCK_HZ_DEF = 25000000;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    localparam logic [WORD_W-1:0] CTRL_WORD     = 16'h2000;
    localparam logic [WORD_W-1:0] CHIP_RST_WORD = 16'h0100;
    localparam logic [WORD_W-1:0] TAG_CH0       = 16'h4000;
    localparam logic [WORD_W-1:0] TAG_CH1       = 16'h8000;
    localparam logic [WORD_W-1:0] WAVE_TRI_BITS = 16'h0002;
    localparam logic [WORD_W-1:0] WAVE_SQR_BITS = 16'h0028;

    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_START_HZ = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_PERIOD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_HZ        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_WAVE     = 3'd5;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK     = 2'd0,
        KIND_SET      = 2'd1,
        KIND_CHIP_RST = 2'd2
    } kind_t;

    typedef enum logic [WAVE_W-1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_TRI    = 2'd1,
        WAVE_SQUARE = 2'd2
    } wave_t;

    typedef enum logic {
        OP_FREQ,
        OP_CHIP_RST
    } op_t;

    typedef enum logic [1:0] {
        SEQ_CTRL,
        SEQ_LSB,
        SEQ_MSB
    } seq_t;

    typedef struct packed {
        op_t               op;
        logic [FREQ_W-1:0] freq;
        logic              chan;
        logic [WAVE_W-1:0] wave;
    } cmd_t;

    typedef struct packed {
        op_t               op;
        logic [TW_W-1:0]   tw;
        logic              chan;
        logic [WAVE_W-1:0] wave;
    } tw_cmd_t;

    function automatic logic [WORD_W-1:0] ctrl_word(input logic [WAVE_W-1:0] code);
        logic [WORD_W-1:0] bits;
        unique case (wave_t'(code))
            WAVE_TRI:    bits = WAVE_TRI_BITS;
            WAVE_SQUARE: bits = WAVE_SQR_BITS;
            default:     bits = '0;
        endcase
        return CTRL_WORD | bits;
    endfunction

endpackage

@@ design/dsw_front.sv @@
// Front end: configuration registers, input acceptance and sweep timing state.
module dsw_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dsw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dsw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dsw_pkg::KIND_W-1:0]    kind,
    input  logic [dsw_pkg::FREQ_W-1:0]    frequency_hz,
    input  logic                          channel,
    input  logic [dsw_pkg::WAVE_W-1:0]    wave_shape,
    input  logic                          q_full,
    output logic                          q_push,
    output dsw_pkg::cmd_t                 q_data
);
    import dsw_pkg::*;

    logic              enable_reg;
    logic [FREQ_W-1:0] start_reg;
    logic [CNT_W-1:0]  period_reg;
    logic [CNT_W-1:0]  interval_reg;
    logic [FREQ_W-1:0] step_reg;
    logic [WAVE_W-1:0] wave_reg;

    logic [FREQ_W-1:0] freq_reg, freq_next;
    logic [CNT_W-1:0]  restart_reg, restart_next;
    logic [CNT_W-1:0]  since_step_reg, since_step_next;

    logic              accept;
    logic [CNT_W-1:0]  restart_inc;
    logic [CNT_W-1:0]  since_step_inc;
    logic [FREQ_W:0]   sum;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    assign restart_inc    = (restart_reg == CNT_MAX) ? restart_reg : restart_reg + 1'b1;
    assign since_step_inc = (since_step_reg == CNT_MAX) ? since_step_reg
                                                        : since_step_reg + 1'b1;
    assign sum = {1'b0, freq_reg} + {1'b0, step_reg};

    always_comb
    begin
        freq_next       = freq_reg;
        restart_next    = restart_reg;
        since_step_next = since_step_reg;
        q_push          = 1'b0;
        q_data.op       = OP_FREQ;
        q_data.freq     = frequency_hz;
        q_data.chan     = channel;
        q_data.wave     = wave_shape;
        if (accept)
        begin
            unique case (kind_t'(kind))
                KIND_SET:
                begin
                    q_push = 1'b1;
                end
                KIND_CHIP_RST:
                begin
                    q_push    = 1'b1;
                    q_data.op = OP_CHIP_RST;
                end
                KIND_TICK:
                begin
                    if (enable_reg)
                    begin
                        q_data.chan = 1'b0;
                        q_data.wave = wave_reg;
                        if (restart_inc > period_reg)
                        begin
                            freq_next       = start_reg;
                            restart_next    = '0;
                            since_step_next = '0;
                            q_push          = 1'b1;
                            q_data.freq     = start_reg;
                        end
                        else if (since_step_inc >= interval_reg)
                        begin
                            freq_next       = sum[FREQ_W] ? FREQ_MAX : sum[FREQ_W-1:0];
                            restart_next    = restart_inc;
                            since_step_next = '0;
                            q_push          = 1'b1;
                            q_data.freq     = freq_next;
                        end
                        else
                        begin
                            restart_next    = restart_inc;
                            since_step_next = since_step_inc;
                        end
                    end
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            start_reg      <= FREQ_W'(1);
            period_reg     <= CNT_W'(1);
            interval_reg   <= CNT_W'(1);
            step_reg       <= FREQ_W'(1);
            wave_reg       <= WAVE_W'(WAVE_SINE);
            freq_reg       <= FREQ_W'(1);
            restart_reg    <= '0;
            since_step_reg <= '0;
        end
        else
        begin
            freq_reg       <= freq_next;
            restart_reg    <= restart_next;
            since_step_reg <= since_step_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SWEEP_ENABLE:   enable_reg   <= cfg_data[0];
                    CFG_SWEEP_START_HZ: start_reg    <= cfg_data[FREQ_W-1:0];
                    CFG_SWEEP_PERIOD:   period_reg   <= cfg_data[CNT_W-1:0];
                    CFG_STEP_INTERVAL:  interval_reg <= cfg_data[CNT_W-1:0];
                    CFG_STEP_HZ:        step_reg     <= cfg_data[FREQ_W-1:0];
                    CFG_SWEEP_WAVE:     wave_reg     <= cfg_data[WAVE_W-1:0];
                    default:            enable_reg   <= enable_reg;
                endcase
            end
        end
    end

endmodule

@@ design/dsw_fifo.sv @@
// Short command queue between the front end and the word emitter.
module dsw_fifo #(
    parameter int DEPTH = dsw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dsw_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output dsw_pkg::cmd_t pop_data,
    output logic          empty
);
    import dsw_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t            mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("Queue count exceeds depth.");

endmodule

@@ design/dsw_conv.sv @@
// Pipelined conversion of a frequency in hertz to a 28-bit tuning word.
module dsw_conv #(
    parameter int MASTER_CLOCK_HZ = dsw_pkg::MASTER_CLOCK_HZ_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dsw_pkg::cmd_t    in_cmd,
    output logic             out_valid,
    input  logic             out_ready,
    output dsw_pkg::tw_cmd_t out_cmd
);
    import dsw_pkg::*;

    localparam int MW    = $clog2(MASTER_CLOCK_HZ + 1);
    localparam int SHIFT = FREQ_W + TW_W + 1;
    localparam longint unsigned RECIP = (64'd1 << SHIFT) / MASTER_CLOCK_HZ;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int LO_W  = RW / 2;
    localparam int HI_W  = RW - LO_W;
    localparam int SUM_W = (FREQ_W + RW > SHIFT + 1) ? FREQ_W + RW : SHIFT + 1;
    localparam int QS    = SHIFT - TW_W;
    localparam logic [RW-1:0] RECIP_V  = RW'(RECIP);
    localparam logic [MW:0]   M_V      = (MW + 1)'(MASTER_CLOCK_HZ);
    localparam logic [MW+1:0] TWO_M_V  = (MW + 2)'(2 * MASTER_CLOCK_HZ);

    logic [3:0] v_reg;
    logic [4:0] rdy;

    cmd_t                   c1_reg, c2_reg, c3_reg;
    logic [FREQ_W+LO_W-1:0] p_lo_reg;
    logic [FREQ_W+HI_W-1:0] p_hi_reg;
    logic [TW_W-1:0]        q2_reg, q3_reg;
    logic [MW:0]            rem_reg;
    tw_cmd_t                c4_reg;

    logic [SUM_W-1:0]       sum;
    logic [2*MW+1:0]        mprod;

    assign rdy[4] = out_ready;
    assign rdy[3] = !v_reg[3] || rdy[4];
    assign rdy[2] = !v_reg[2] || rdy[3];
    assign rdy[1] = !v_reg[1] || rdy[2];
    assign rdy[0] = !v_reg[0] || rdy[1];

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[3];
    assign out_cmd   = c4_reg;

    assign sum   = SUM_W'(p_lo_reg) + (SUM_W'(p_hi_reg) << LO_W);
    assign mprod = (2 * MW + 2)'(q2_reg[MW:0]) * (2 * MW + 2)'(M_V[MW-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (rdy[1])
            begin
                v_reg[1] <= v_reg[0];
            end
            if (rdy[2])
            begin
                v_reg[2] <= v_reg[1];
            end
            if (rdy[3])
            begin
                v_reg[3] <= v_reg[2];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            c1_reg   <= in_cmd;
            p_lo_reg <= (FREQ_W + LO_W)'(in_cmd.freq) * (FREQ_W + LO_W)'(RECIP_V[LO_W-1:0]);
            p_hi_reg <= (FREQ_W + HI_W)'(in_cmd.freq) * (FREQ_W + HI_W)'(RECIP_V[RW-1:LO_W]);
        end
        if (rdy[1])
        begin
            c2_reg <= c1_reg;
            q2_reg <= sum[QS +: TW_W];
        end
        if (rdy[2])
        begin
            c3_reg  <= c2_reg;
            q3_reg  <= q2_reg;
            rem_reg <= (MW + 1)'(0) - mprod[MW:0];
        end
        if (rdy[3])
        begin
            c4_reg.op   <= c3_reg.op;
            c4_reg.chan <= c3_reg.chan;
            c4_reg.wave <= c3_reg.wave;
            c4_reg.tw   <= (rem_reg >= M_V) ? q3_reg + 1'b1 : q3_reg;
        end
    end

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[2] |-> ({1'b0, rem_reg} < TWO_M_V))
        else $error("Tuning word estimate is off by more than one.");

endmodule

@@ design/dsw_back.sv @@
// Back end: tuning word conversion and serialization of the control words.
module dsw_back #(
    parameter int MASTER_CLOCK_HZ = dsw_pkg::MASTER_CLOCK_HZ_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  dsw_pkg::cmd_t              q_data,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [dsw_pkg::WORD_W-1:0] word,
    output logic                       last
);
    import dsw_pkg::*;

    logic    conv_in_ready;
    logic    conv_valid;
    logic    conv_ready;
    tw_cmd_t conv_cmd;

    logic    busy_reg, busy_next;
    seq_t    seq_reg, seq_next;
    tw_cmd_t cmd_reg, cmd_next;

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] word_reg;
    logic              last_reg;

    logic              out_free;
    logic              cur_last;
    logic [WORD_W-1:0] tag;
    logic [WORD_W-1:0] word_sel;

    dsw_conv #(
        .MASTER_CLOCK_HZ(MASTER_CLOCK_HZ)
    ) u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!q_empty),
        .in_ready (conv_in_ready),
        .in_cmd   (q_data),
        .out_valid(conv_valid),
        .out_ready(conv_ready),
        .out_cmd  (conv_cmd)
    );

    assign q_pop     = !q_empty && conv_in_ready;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cur_last  = (cmd_reg.op == OP_CHIP_RST) || (seq_reg == SEQ_MSB);
    assign conv_ready = !busy_reg || (out_free && cur_last);

    assign out_valid = out_valid_reg;
    assign word      = word_reg;
    assign last      = last_reg;

    always_comb
    begin
        busy_next = busy_reg;
        seq_next  = seq_reg;
        cmd_next  = cmd_reg;
        if (busy_reg && out_free)
        begin
            if (cur_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                seq_next = (seq_reg == SEQ_CTRL) ? SEQ_LSB : SEQ_MSB;
            end
        end
        if (conv_valid && conv_ready)
        begin
            busy_next = 1'b1;
            seq_next  = SEQ_CTRL;
            cmd_next  = conv_cmd;
        end
    end

    always_comb
    begin
        tag = cmd_reg.chan ? TAG_CH1 : TAG_CH0;
        unique case (seq_reg)
            SEQ_CTRL: word_sel = (cmd_reg.op == OP_CHIP_RST) ? CHIP_RST_WORD
                                                              : ctrl_word(cmd_reg.wave);
            SEQ_LSB:  word_sel = WORD_W'(cmd_reg.tw[HALF_W-1:0]) | tag;
            SEQ_MSB:  word_sel = WORD_W'(cmd_reg.tw[TW_W-1:HALF_W]) | tag;
            default:  word_sel = '0;
        endcase
        out_valid_next = out_free ? busy_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            seq_reg       <= SEQ_CTRL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (out_free && busy_reg)
        begin
            word_reg <= word_sel;
            last_reg <= cur_last;
        end
    end

    a_rst_single: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cmd_reg.op == OP_CHIP_RST) |-> (seq_reg == SEQ_CTRL))
        else $error("Chip reset transaction advanced past its single word.");

    a_msb_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && out_free && seq_reg == SEQ_MSB) |=> (out_valid_reg && last_reg))
        else $error("High frequency word was not marked last.");

endmodule

@@ design/dds_sweep_word_generator.sv @@
// Top level of the sweep tuning word generator for a 28-bit synthesis chip.
// Each accepted transaction is a millisecond tick, a set-frequency request or a chip
// reset; a set request or a sweep tick that steps or restarts yields three 16-bit words
// (control, low 14 bits, high 14 bits), a chip reset yields the single word 0x0100, and
// other ticks yield nothing. Input transactions are taken one per cycle while the
// command queue has room; the words leave at one per cycle from the output register
// while out_stall is low, three per frequency transaction and one per chip reset.
// The first word reaches the output register through the queue and the four-stage
// reciprocal multiply that computes floor(f * 2^28 / MASTER_CLOCK_HZ), then the word
// sequencer. No clearing pass follows reset.
module dds_sweep_word_generator #(
    parameter int MASTER_CLOCK_HZ = dsw_pkg::MASTER_CLOCK_HZ_DEF,
    parameter int QUEUE_DEPTH     = dsw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dsw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dsw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [dsw_pkg::KIND_W-1:0]     kind,
    input  logic [dsw_pkg::FREQ_W-1:0]     frequency_hz,
    input  logic                           channel,
    input  logic [dsw_pkg::WAVE_W-1:0]     wave_shape,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [dsw_pkg::WORD_W-1:0]     word,
    output logic                           last
);
    import dsw_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t q_push_data;
    logic q_pop;
    cmd_t q_pop_data;
    logic q_empty;

    dsw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .frequency_hz(frequency_hz),
        .channel     (channel),
        .wave_shape  (wave_shape),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_push_data)
    );

    dsw_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_push_data),
        .full     (q_full),
        .pop      (q_pop),
        .pop_data (q_pop_data),
        .empty    (q_empty)
    );

    dsw_back #(
        .MASTER_CLOCK_HZ(MASTER_CLOCK_HZ)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_pop_data),
        .q_pop    (q_pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .word     (word),
        .last     (last)
    );

endmodule
